FILE: rtl/core/mrtfs_pkg.sv
// ----------------------------------------------------------------------------
// mrtfs_pkg
// Shared constants and types for the multi-rate tick flag scheduler: channel
// count limit, period table, field widths and action codes.
// ----------------------------------------------------------------------------
package mrtfs_pkg;

  // Channel limit and fixed field widths
  localparam int CHAN_MAX   = 9;
  localparam int FLAG_W     = 9;
  localparam int TICK_W     = 32;
  localparam int PERIOD_W   = 10;

  // Defaults for the top-level parameters
  localparam int DEF_NUM_RATES   = 9;
  localparam int DEF_COUNT_WIDTH = 32;

  // Periods in ticks, fastest channel first
  localparam logic [PERIOD_W-1:0] CHAN_PERIOD [CHAN_MAX] = '{
    10'd1, 10'd2, 10'd4, 10'd10, 10'd20, 10'd50, 10'd100, 10'd250, 10'd1000
  };

  // Item action codes
  typedef enum logic [0:0] {
    ACT_INIT   = 1'b0,
    ACT_HANDLE = 1'b1
  } action_t;

endpackage

FILE: rtl/core/multi_rate_tick_flag_scheduler_unit.sv
// ----------------------------------------------------------------------------
// multi_rate_tick_flag_scheduler_unit
// Path: input register, then result register, which holds the result.
// Throughput: one item per cycle while out_ready does not stall the result
// register; the reference update and priority pick are done between the two
// registers.
// Reset: synchronous; all references cleared to zero, both stages emptied.
// ----------------------------------------------------------------------------
module multi_rate_tick_flag_scheduler_unit #(
  parameter int NUM_RATES   = mrtfs_pkg::DEF_NUM_RATES,
  parameter int COUNT_WIDTH = mrtfs_pkg::DEF_COUNT_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [0:0]                      action,
  input  logic [mrtfs_pkg::TICK_W-1:0]    tick_count,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mrtfs_pkg::FLAG_W-1:0]    rate_flags
);

  logic                          s1_valid;
  logic [0:0]                    s1_action;
  logic [mrtfs_pkg::TICK_W-1:0]  s1_tick;
  logic                          s1_advance;
  logic [mrtfs_pkg::FLAG_W-1:0]  flags_next;

  // Stage 1 moves on when the result register is free or draining
  assign s1_advance = !out_valid || out_ready;
  assign in_ready   = !s1_valid || s1_advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action <= action;
      s1_tick   <= tick_count;
    end
  end

  // Scheduler core
  mrtfs_sched #(
    .NUM_RATES   (NUM_RATES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_sched (
    .clk        (clk),
    .rst        (rst),
    .en         (s1_valid && s1_advance),
    .action     (s1_action),
    .tick_count (s1_tick),
    .rate_flags (flags_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_advance) begin
      rate_flags <= (s1_action == mrtfs_pkg::ACT_INIT) ? '0 : flags_next;
    end
  end

  // Checks
  a_onehot_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(rate_flags))
    else $error("rate_flags not one-hot");

  a_init_zero: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_advance && s1_action == mrtfs_pkg::ACT_INIT)
      |=> (out_valid && rate_flags == '0))
    else $error("init item gave nonzero flags");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled without full pipeline");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !s1_valid))
    else $error("stages not empty after reset");

endmodule

FILE: rtl/core/mrtfs_sched.sv
// ----------------------------------------------------------------------------
// mrtfs_sched
// Reference tick registers and the per-channel elapsed/compare units with a
// fastest-first priority pick. Flags are combinational from the current
// references; references update on the enable.
// ----------------------------------------------------------------------------
module mrtfs_sched #(
  parameter int NUM_RATES   = mrtfs_pkg::DEF_NUM_RATES,
  parameter int COUNT_WIDTH = mrtfs_pkg::DEF_COUNT_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic [0:0]                      action,
  input  logic [mrtfs_pkg::TICK_W-1:0]    tick_count,
  output logic [mrtfs_pkg::FLAG_W-1:0]    rate_flags
);

  localparam int NUM_CH = (NUM_RATES < mrtfs_pkg::CHAN_MAX) ? NUM_RATES
                                                             : mrtfs_pkg::CHAN_MAX;
  localparam int CMP_W  = (COUNT_WIDTH > mrtfs_pkg::PERIOD_W) ? COUNT_WIDTH
                                                               : mrtfs_pkg::PERIOD_W;

  logic [COUNT_WIDTH-1:0] ref_tick [NUM_CH];
  logic [COUNT_WIDTH-1:0] now_tick;
  logic [NUM_CH-1:0]      due;
  logic [NUM_CH-1:0]      fire;

  // Current tick reduced to the counter width
  assign now_tick = COUNT_WIDTH'(tick_count);

  // Elapsed-time compare, one unit per channel
  for (genvar c = 0; c < NUM_CH; c++) begin : g_chan
    logic [COUNT_WIDTH-1:0] elapsed;
    assign elapsed = now_tick - ref_tick[c];
    assign due[c]  = (CMP_W'(elapsed) >= CMP_W'(mrtfs_pkg::CHAN_PERIOD[c]));
  end

  // Fastest due channel wins: isolate lowest set bit
  assign fire = due & (~due + NUM_CH'(1));

  // Channel c drives flag bit NUM_RATES-1-c when that bit exists
  for (genvar b = 0; b < mrtfs_pkg::FLAG_W; b++) begin : g_flag
    localparam int CH = NUM_RATES - 1 - b;
    if (CH >= 0 && CH < NUM_CH) begin : g_on
      assign rate_flags[b] = fire[CH];
    end else begin : g_off
      assign rate_flags[b] = 1'b0;
    end
  end

  // Reference update: init loads all, handle advances the winner
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CH; c++) begin
        ref_tick[c] <= '0;
      end
    end else if (en) begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (action == mrtfs_pkg::ACT_INIT) begin
          ref_tick[c] <= now_tick;
        end else if (fire[c]) begin
          ref_tick[c] <= ref_tick[c] + COUNT_WIDTH'(mrtfs_pkg::CHAN_PERIOD[c]);
        end
      end
    end
  end

endmodule
